/* rtl/postfix_invariant_evaluator_top_assert.svh */
// Assertion macros used by the evaluator back end.
`ifndef POSTFIX_INVARIANT_EVALUATOR_TOP_ASSERT_SVH
`define POSTFIX_INVARIANT_EVALUATOR_TOP_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define PIE_ASSERT_ALWAYS(name, ck, rn, cond) \
	name: assert property (@(posedge ck) disable iff (!rn) (cond)) \
		else $error("invariant violated");

// Antecedent implies consequent in the same cycle.
`define PIE_ASSERT_IMPLIES(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("implication violated");

// Antecedent implies consequent in the next cycle.
`define PIE_ASSERT_NEXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

/* rtl/pie_pkg.sv */
// Types and codes shared by the postfix invariant evaluator.
package pie_pkg;

	localparam logic [1:0] KIND_CONST = 2'd0;
	localparam logic [1:0] KIND_ATTR  = 2'd1;
	localparam logic [1:0] KIND_INT   = 2'd2;
	localparam logic [1:0] KIND_BOOL  = 2'd3;
	localparam logic [1:0] KIND_OPER  = 2'd2;

	localparam logic [1:0] CMD_NODE = 2'd0;
	localparam logic [1:0] CMD_VIEW = 2'd1;
	localparam logic [1:0] CMD_MAP  = 2'd2;

	localparam logic [1:0] CL_NOP  = 2'd0;
	localparam logic [1:0] CL_VIEW = 2'd1;
	localparam logic [1:0] CL_MAP  = 2'd2;
	localparam logic [1:0] CL_NODE = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_UNDER  = 3'd1;
	localparam logic [2:0] ST_OVER   = 3'd2;
	localparam logic [2:0] ST_LOOKUP = 3'd3;
	localparam logic [2:0] ST_DIVZ   = 3'd4;

	localparam logic [3:0] OP_AND     = 4'd0;
	localparam logic [3:0] OP_IMPLY   = 4'd1;
	localparam logic [3:0] OP_OR      = 4'd2;
	localparam logic [3:0] OP_DIFFER  = 4'd3;
	localparam logic [3:0] OP_EQUAL   = 4'd4;
	localparam logic [3:0] OP_GREATER = 4'd5;
	localparam logic [3:0] OP_LOWER   = 4'd6;
	localparam logic [3:0] OP_DIV     = 4'd7;
	localparam logic [3:0] OP_MINUS   = 4'd8;
	localparam logic [3:0] OP_MOD     = 4'd9;
	localparam logic [3:0] OP_MUL     = 4'd10;
	localparam logic [3:0] OP_PLUS    = 4'd11;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] val;
		logic        neg;
		logic [15:0] hash;
		logic [7:0]  quant;
	} operand_t;

	typedef struct packed {
		logic [7:0]  conn;
		logic [15:0] hash;
		logic [7:0]  quant;
		logic [7:0]  target;
	} map_entry_t;

	typedef struct packed {
		logic [1:0]  cls;
		logic [1:0]  kind;
		logic [31:0] value;
		logic        negated;
		logic [15:0] hash;
		logic [7:0]  quant;
		logic [3:0]  op;
		logic        last;
		logic [3:0]  slot;
		logic [7:0]  conn;
		logic [7:0]  target;
		logic        fresh;
	} item_t;

endpackage

/* rtl/pie_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/pie_div.sv */
// Iterative unsigned restoring divider, one quotient bit per cycle.
module pie_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient,
	output logic [31:0] remainder
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] div_q;
	logic [32:0] rem_sh;
	logic [32:0] diff;

	assign rem_sh = {rem_q[31:0], quo_q[31]};
	assign diff   = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[31:0];

endmodule

/* rtl/pie_front.sv */
// Front end: input acceptance, command classification and a two-entry queue.
module pie_front #(
	parameter int VIEW_ENTRIES = 16,
	parameter int MAP_DEPTH    = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          command,
	input  logic [1:0]          node_kind,
	input  logic [31:0]         value,
	input  logic                negated,
	input  logic [15:0]         attr_hash,
	input  logic [7:0]          quantifier,
	input  logic [3:0]          op_code,
	input  logic                last_node,
	input  logic [3:0]          slot,
	input  logic [7:0]          connective_number,
	input  logic [7:0]          target_index,
	input  logic                fresh,
	output logic                q_valid,
	input  logic                q_pop,
	output pie_pkg::item_t      q_item
);

	pie_pkg::item_t item;
	pie_pkg::item_t q_mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     qcnt_q;
	logic           accept;
	logic           push;

	always_comb begin
		item.kind    = node_kind;
		item.value   = value;
		item.negated = negated;
		item.hash    = attr_hash;
		item.quant   = quantifier;
		item.op      = op_code;
		item.last    = last_node;
		item.slot    = slot;
		item.conn    = connective_number;
		item.target  = target_index;
		item.fresh   = fresh;
		case (command)
			pie_pkg::CMD_NODE: item.cls = pie_pkg::CL_NODE;
			pie_pkg::CMD_VIEW: item.cls = (9'(slot) < 9'(VIEW_ENTRIES)) ?
				pie_pkg::CL_VIEW : pie_pkg::CL_NOP;
			pie_pkg::CMD_MAP:  item.cls = (9'(slot) < 9'(MAP_DEPTH)) ?
				pie_pkg::CL_MAP : pie_pkg::CL_NOP;
			default:           item.cls = pie_pkg::CL_NOP;
		endcase
	end

	assign in_stall = (qcnt_q == 2'd2);
	assign accept   = in_valid && !in_stall;
	// out-of-range writes and unknown commands are dropped here
	assign push     = accept && (item.cls != pie_pkg::CL_NOP);
	assign q_valid  = (qcnt_q != 2'd0);
	assign q_item   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			qcnt_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			qcnt_q <= qcnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= item;
		end
	end

endmodule

/* rtl/pie_back.sv */
// Back end: table writes, operand stack, attribute lookup and operators.
module pie_back #(
	parameter int STACK_DEPTH  = 16,
	parameter int VIEW_ENTRIES = 16,
	parameter int MAP_DEPTH    = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [4:0]     map_count,
	input  logic           q_valid,
	output logic           q_pop,
	input  pie_pkg::item_t q_item,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [31:0]    out_value,
	output logic           out_bool,
	output logic [2:0]     out_status
);

`include "postfix_invariant_evaluator_top_assert.svh"

	localparam int CW  = $clog2(STACK_DEPTH + 1);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int VAW = (VIEW_ENTRIES > 1) ? $clog2(VIEW_ENTRIES) : 1;
	localparam int MAW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int MIW = $clog2(MAP_DEPTH + 1);
	localparam int OPW = $bits(pie_pkg::operand_t);
	localparam int MEW = $bits(pie_pkg::map_entry_t);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RDB   = 4'd1;
	localparam logic [3:0] S_RDA   = 4'd2;
	localparam logic [3:0] S_CAPA  = 4'd3;
	localparam logic [3:0] S_RES   = 4'd4;
	localparam logic [3:0] S_MRD   = 4'd5;
	localparam logic [3:0] S_MCMP  = 4'd6;
	localparam logic [3:0] S_VRD   = 4'd7;
	localparam logic [3:0] S_EXEC  = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_PUSH  = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;
	localparam logic [3:0] S_FINRD = 4'd12;
	localparam logic [3:0] S_OUT   = 4'd13;

	// control state
	logic [3:0]             state_q, state_d;
	logic [CW-1:0]          cnt_q, cnt_d;
	logic [7:0]             conn_q, conn_d;
	logic [2:0]             err_q, err_d;
	logic                   which_q, which_d;
	logic                   out_valid_q;
	logic [VIEW_ENTRIES-1:0] fresh_q;

	// payload
	pie_pkg::item_t         item_q, item_d;
	pie_pkg::operand_t      o1_q, o1_d, o2_q, o2_d, cur, top;
	logic [31:0]            va_q, va_d, vb_q, vb_d;
	logic [MIW-1:0]         midx_q, midx_d, lim;
	logic [31:0]            res_q, res_d;
	logic [1:0]             reskind_q, reskind_d;
	logic                   aneg_q, aneg_d, qneg_q, qneg_d;
	logic [31:0]            fin_val_q, fin_val_d;
	logic                   fin_bool_q, fin_bool_d;
	logic [31:0]            out_val_q;
	logic                   out_bool_q;
	logic [2:0]             out_st_q;

	// memories
	logic                   stk_we;
	logic [SAW-1:0]         stk_waddr, stk_raddr;
	logic [OPW-1:0]         stk_wdata, stk_rdata;
	logic                   view_we;
	logic [VAW-1:0]         view_waddr, view_raddr;
	logic [31:0]            view_rdata;
	logic                   map_we;
	logic [MAW-1:0]         map_raddr;
	logic [MEW-1:0]         map_wdata, map_rdata;
	pie_pkg::map_entry_t    mentry, mwr;
	pie_pkg::operand_t      pushed;

	// divider
	logic                   div_start, div_done;
	logic [31:0]            div_a, div_b, div_q, div_r;

	logic                   out_load;
	logic [31:0]            rsv, rsv_neg;
	logic                   neg_ok;
	logic                   hit;
	logic                   tgt_ok;

	assign cur    = which_q ? o2_q : o1_q;
	assign top    = pie_pkg::operand_t'(stk_rdata);
	assign mentry = pie_pkg::map_entry_t'(map_rdata);
	assign lim    = (8'(map_count) > 8'(MAP_DEPTH)) ? MIW'(MAP_DEPTH) : MIW'(map_count);
	assign hit    = (mentry.conn == conn_q) && (mentry.hash == cur.hash) &&
		(mentry.quant == cur.quant);
	assign tgt_ok = (9'(mentry.target) < 9'(VIEW_ENTRIES)) &&
		fresh_q[mentry.target[VAW-1:0]];
	assign view_raddr = mentry.target[VAW-1:0];
	assign map_raddr  = midx_q[MAW-1:0];

	// resolved operand value, negated for arithmetic and compare operators when its flag is set
	assign rsv     = (state_q == S_VRD) ? view_rdata : cur.val;
	assign neg_ok  = (item_q.op > pie_pkg::OP_OR) && cur.neg;
	assign rsv_neg = neg_ok ? (32'd0 - rsv) : rsv;

	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		mwr.conn   = q_item.conn;
		mwr.hash   = q_item.hash;
		mwr.quant  = q_item.quant;
		mwr.target = q_item.target;
		map_wdata  = MEW'(mwr);
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		conn_d     = conn_q;
		err_d      = err_q;
		which_d    = which_q;
		item_d     = item_q;
		o1_d       = o1_q;
		o2_d       = o2_q;
		va_d       = va_q;
		vb_d       = vb_q;
		midx_d     = midx_q;
		res_d      = res_q;
		reskind_d  = reskind_q;
		aneg_d     = aneg_q;
		qneg_d     = qneg_q;
		fin_val_d  = fin_val_q;
		fin_bool_d = fin_bool_q;
		q_pop      = 1'b0;
		stk_we     = 1'b0;
		stk_waddr  = cnt_q[SAW-1:0];
		stk_raddr  = cnt_q[SAW-1:0];
		pushed     = '0;
		view_we    = 1'b0;
		view_waddr = VAW'(q_item.slot);
		map_we     = 1'b0;
		div_start  = 1'b0;
		div_a      = va_q[31] ? (32'd0 - va_q) : va_q;
		div_b      = vb_q[31] ? (32'd0 - vb_q) : vb_q;

		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop  = 1'b1;
					item_d = q_item;
					case (q_item.cls)
						pie_pkg::CL_VIEW: begin
							view_we = 1'b1;
						end
						pie_pkg::CL_MAP: begin
							map_we = 1'b1;
						end
						pie_pkg::CL_NODE: begin
							if (q_item.last) begin
								state_d = S_FIN;
							end
							if (err_q == pie_pkg::ST_OK) begin
								if (q_item.kind == pie_pkg::KIND_CONST ||
									q_item.kind == pie_pkg::KIND_ATTR) begin
									if (cnt_q >= CW'(STACK_DEPTH)) begin
										err_d = pie_pkg::ST_OVER;
									end else begin
										stk_we       = 1'b1;
										pushed.kind  = q_item.kind;
										pushed.val   = q_item.value;
										pushed.neg   = q_item.negated;
										pushed.hash  = q_item.hash;
										pushed.quant = q_item.quant;
										cnt_d        = cnt_q + CW'(1);
									end
								end else if (q_item.kind == pie_pkg::KIND_OPER) begin
									if (cnt_q < CW'(2)) begin
										err_d = pie_pkg::ST_UNDER;
									end else begin
										cnt_d   = cnt_q - CW'(2);
										state_d = S_RDB;
										if (q_item.op <= pie_pkg::OP_OR) begin
											conn_d = conn_q + 8'd1;
										end
									end
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_RDB: begin
				stk_raddr = SAW'(cnt_q + CW'(1));
				state_d   = S_RDA;
			end
			S_RDA: begin
				o2_d    = top;
				state_d = S_CAPA;
			end
			S_CAPA: begin
				o1_d    = top;
				which_d = 1'b0;
				state_d = S_RES;
			end
			S_RES: begin
				if (cur.kind == pie_pkg::KIND_ATTR) begin
					midx_d  = '0;
					state_d = S_MRD;
				end else begin
					if (which_q) begin
						vb_d    = rsv_neg;
						state_d = S_EXEC;
					end else begin
						va_d    = rsv_neg;
						which_d = 1'b1;
					end
				end
			end
			S_MRD: begin
				if (midx_q >= lim) begin
					err_d   = pie_pkg::ST_LOOKUP;
					state_d = item_q.last ? S_FIN : S_IDLE;
				end else begin
					state_d = S_MCMP;
				end
			end
			S_MCMP: begin
				if (hit) begin
					if (tgt_ok) begin
						state_d = S_VRD;
					end else begin
						err_d   = pie_pkg::ST_LOOKUP;
						state_d = item_q.last ? S_FIN : S_IDLE;
					end
				end else begin
					midx_d  = midx_q + MIW'(1);
					state_d = S_MRD;
				end
			end
			S_VRD: begin
				if (which_q) begin
					vb_d    = rsv_neg;
					state_d = S_EXEC;
				end else begin
					va_d    = rsv_neg;
					which_d = 1'b1;
					state_d = S_RES;
				end
			end
			S_EXEC: begin
				reskind_d = pie_pkg::KIND_BOOL;
				state_d   = S_PUSH;
				case (item_q.op)
					pie_pkg::OP_AND:     res_d = 32'((va_q != '0) && (vb_q != '0));
					pie_pkg::OP_IMPLY:   res_d = 32'((va_q == '0) || (vb_q != '0));
					pie_pkg::OP_OR:      res_d = 32'((va_q != '0) || (vb_q != '0));
					pie_pkg::OP_DIFFER:  res_d = 32'(va_q != vb_q);
					pie_pkg::OP_EQUAL:   res_d = 32'(va_q == vb_q);
					pie_pkg::OP_GREATER: res_d = 32'($signed(va_q) > $signed(vb_q));
					pie_pkg::OP_LOWER:   res_d = 32'($signed(va_q) < $signed(vb_q));
					pie_pkg::OP_MINUS: begin
						reskind_d = pie_pkg::KIND_INT;
						res_d     = va_q - vb_q;
					end
					pie_pkg::OP_MUL: begin
						reskind_d = pie_pkg::KIND_INT;
						res_d     = va_q * vb_q;
					end
					pie_pkg::OP_PLUS: begin
						reskind_d = pie_pkg::KIND_INT;
						res_d     = va_q + vb_q;
					end
					pie_pkg::OP_DIV, pie_pkg::OP_MOD: begin
						reskind_d = pie_pkg::KIND_INT;
						if (vb_q == '0) begin
							err_d   = pie_pkg::ST_DIVZ;
							state_d = item_q.last ? S_FIN : S_IDLE;
						end else begin
							div_start = 1'b1;
							aneg_d    = va_q[31];
							qneg_d    = va_q[31] ^ vb_q[31];
							state_d   = S_DIV;
						end
					end
					default: begin
						reskind_d = pie_pkg::KIND_INT;
						res_d     = '0;
					end
				endcase
			end
			S_DIV: begin
				if (div_done) begin
					if (item_q.op == pie_pkg::OP_DIV) begin
						res_d = qneg_q ? (32'd0 - div_q) : div_q;
					end else begin
						res_d = aneg_q ? (32'd0 - div_r) : div_r;
					end
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				stk_we      = 1'b1;
				pushed.kind = reskind_q;
				pushed.val  = res_q;
				cnt_d       = cnt_q + CW'(1);
				state_d     = item_q.last ? S_FIN : S_IDLE;
			end
			S_FIN: begin
				fin_val_d  = '0;
				fin_bool_d = 1'b0;
				if (err_q == pie_pkg::ST_OK && cnt_q != '0) begin
					stk_raddr = SAW'(cnt_q - CW'(1));
					state_d   = S_FINRD;
				end else begin
					state_d = S_OUT;
				end
			end
			S_FINRD: begin
				// an unresolved attribute on top reports zero
				if (top.kind != pie_pkg::KIND_ATTR) begin
					fin_val_d  = top.val;
					fin_bool_d = (top.kind == pie_pkg::KIND_BOOL);
				end
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_load) begin
					cnt_d   = '0;
					conn_d  = '0;
					err_d   = pie_pkg::ST_OK;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		stk_wdata = OPW'(pushed);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			conn_q      <= '0;
			err_q       <= pie_pkg::ST_OK;
			which_q     <= 1'b0;
			out_valid_q <= 1'b0;
			fresh_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			conn_q  <= conn_d;
			err_q   <= err_d;
			which_q <= which_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (view_we) begin
				fresh_q[view_waddr] <= q_item.fresh;
			end
		end
	end

	always_ff @(posedge clk) begin
		item_q     <= item_d;
		o1_q       <= o1_d;
		o2_q       <= o2_d;
		va_q       <= va_d;
		vb_q       <= vb_d;
		midx_q     <= midx_d;
		res_q      <= res_d;
		reskind_q  <= reskind_d;
		aneg_q     <= aneg_d;
		qneg_q     <= qneg_d;
		fin_val_q  <= fin_val_d;
		fin_bool_q <= fin_bool_d;
		if (out_load) begin
			out_val_q  <= fin_val_q;
			out_bool_q <= fin_bool_q;
			out_st_q   <= err_q;
		end
	end

	pie_ram #(.WIDTH(OPW), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	pie_ram #(.WIDTH(32), .DEPTH(VIEW_ENTRIES)) u_view (
		.clk   (clk),
		.we    (view_we),
		.waddr (view_waddr),
		.wdata (q_item.value),
		.raddr (view_raddr),
		.rdata (view_rdata)
	);

	pie_ram #(.WIDTH(MEW), .DEPTH(MAP_DEPTH)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (MAW'(q_item.slot)),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	pie_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	assign out_valid  = out_valid_q;
	assign out_value  = out_val_q;
	assign out_bool   = out_bool_q;
	assign out_status = out_st_q;

	`PIE_ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q <= CW'(STACK_DEPTH))
	`PIE_ASSERT_IMPLIES(a_push_room, clk, arst_n, state_q == S_PUSH, cnt_q < CW'(STACK_DEPTH))
	`PIE_ASSERT_NEXT(a_clear_after_report, clk, arst_n, out_load, (cnt_q == '0) && (conn_q == '0) && (err_q == pie_pkg::ST_OK))

endmodule

/* rtl/postfix_invariant_evaluator_top.sv */
// Top level of the postfix invariant evaluator: map_count register and front/back wiring.
// Evaluates postfix invariant expressions one node per transaction. A view or mapping
// write is done as the back end pops it. A constant or attribute is pushed as it is
// popped; on the last node the back end then reads the top of stack and presents the
// result. An operator reads both operands, resolves each, executes and pushes its result.
// Each attribute operand adds a map read and compare for every mapping slot searched
// (at most min(map_count, MAP_DEPTH)) and a view read. div and mod also wait for the
// bit-serial divider. The mapping search and the divider set the worst case. A two-entry
// queue lets the input keep taking transactions while the back end works, and the result
// register holds a finished result while the next node is already being processed. No
// clearing pass follows reset; map_count may be written whenever the block is idle.
module postfix_invariant_evaluator_top #(
	parameter int STACK_DEPTH  = 16,
	parameter int VIEW_ENTRIES = 16,
	parameter int MAP_DEPTH    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [1:0]         node_kind,
	input  logic signed [31:0] value,
	input  logic               negated,
	input  logic [15:0]        attr_hash,
	input  logic [7:0]         quantifier,
	input  logic [3:0]         op_code,
	input  logic               last_node,
	input  logic [3:0]         slot,
	input  logic [7:0]         connective_number,
	input  logic [7:0]         target_index,
	input  logic               fresh,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic               result_is_bool,
	output logic [2:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data
);

	logic [4:0]     map_count_q;
	logic           q_valid;
	logic           q_pop;
	pie_pkg::item_t q_item;
	logic [31:0]    out_value;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			map_count_q <= cfg_data;
		end
	end

	pie_front #(
		.VIEW_ENTRIES (VIEW_ENTRIES),
		.MAP_DEPTH    (MAP_DEPTH)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.command           (command),
		.node_kind         (node_kind),
		.value             (value),
		.negated           (negated),
		.attr_hash         (attr_hash),
		.quantifier        (quantifier),
		.op_code           (op_code),
		.last_node         (last_node),
		.slot              (slot),
		.connective_number (connective_number),
		.target_index      (target_index),
		.fresh             (fresh),
		.q_valid           (q_valid),
		.q_pop             (q_pop),
		.q_item            (q_item)
	);

	pie_back #(
		.STACK_DEPTH  (STACK_DEPTH),
		.VIEW_ENTRIES (VIEW_ENTRIES),
		.MAP_DEPTH    (MAP_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.map_count  (map_count_q),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_item     (q_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_value  (out_value),
		.out_bool   (result_is_bool),
		.out_status (status)
	);

	assign result_value = $signed(out_value);

endmodule

/* tb/sv/postfix_invariant_evaluator_top_tb.sv */
// Testbench for the postfix invariant evaluator: directed and random expressions.
`timescale 1ns / 1ps

module postfix_invariant_evaluator_top_tb;

	localparam int DEPTH = 16;
	localparam int VIEWS = 16;
	localparam int MAPS  = 16;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;
	localparam logic [1:0] CMD_UNKNOWN  = 2'd3;

	typedef struct {
		logic [31:0] val;
		logic        is_bool;
		logic [2:0]  st;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] command = '0;
	logic [1:0] node_kind = '0;
	logic signed [31:0] value = '0;
	logic negated = 1'b0;
	logic [15:0] attr_hash = '0;
	logic [7:0] quantifier = '0;
	logic [3:0] op_code = '0;
	logic last_node = 1'b0;
	logic [3:0] slot = '0;
	logic [7:0] connective_number = '0;
	logic [7:0] target_index = '0;
	logic fresh = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] result_value;
	logic result_is_bool;
	logic [2:0] status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [4:0] cfg_data = '0;

	// predictor state
	pie_pkg::operand_t   eval_stack[DEPTH];
	int unsigned         eval_depth;
	logic [7:0]          conn_count;
	logic [2:0]          eval_err;
	logic [31:0]         view_val[VIEWS];
	logic                view_ok[VIEWS];
	pie_pkg::map_entry_t map_tab[MAPS];
	logic [4:0]          map_limit;

	outcome_t expected_results[$];
	int errors = 0;
	int idle_cycles = 0;
	bit stall_busy = 1'b0;  // long out_stall stretches
	bit quiet_stall = 1'b0; // no output stalls

	postfix_invariant_evaluator_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .node_kind(node_kind), .value(value), .negated(negated),
		.attr_hash(attr_hash), .quantifier(quantifier), .op_code(op_code),
		.last_node(last_node), .slot(slot), .connective_number(connective_number),
		.target_index(target_index), .fresh(fresh),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .result_is_bool(result_is_bool), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit fetch_operand(pie_pkg::operand_t o, output logic [31:0] v);
		int lim;
		lim = (map_limit < MAPS) ? int'(map_limit) : MAPS;
		v = '0;
		if (o.kind != pie_pkg::KIND_ATTR) begin
			v = o.val;
			return 1'b1;
		end
		for (int i = 0; i < lim; i++) begin
			if (map_tab[i].conn == conn_count && map_tab[i].hash == o.hash &&
					map_tab[i].quant == o.quant) begin
				if (map_tab[i].target >= VIEWS || !view_ok[map_tab[i].target])
					return 1'b0;
				v = view_val[map_tab[i].target];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [2:0] eval_operator(logic [3:0] op);
		pie_pkg::operand_t a, b, res;
		logic [31:0] va, vb, r, ma, mb, q, m;
		logic [1:0] k;
		if (eval_depth < 2) return pie_pkg::ST_UNDER;
		b = eval_stack[eval_depth - 1];
		a = eval_stack[eval_depth - 2];
		eval_depth -= 2;
		if (op == pie_pkg::OP_AND || op == pie_pkg::OP_IMPLY || op == pie_pkg::OP_OR)
			conn_count++;
		if (!fetch_operand(a, va)) return pie_pkg::ST_LOOKUP;
		if (!fetch_operand(b, vb)) return pie_pkg::ST_LOOKUP;
		if (op > pie_pkg::OP_OR) begin
			if (a.neg) va = -va;
			if (b.neg) vb = -vb;
		end
		k = pie_pkg::KIND_BOOL;
		r = '0;
		case (op)
			pie_pkg::OP_AND:     r = 32'(va != 0 && vb != 0);
			pie_pkg::OP_IMPLY:   r = 32'(va == 0 || vb != 0);
			pie_pkg::OP_OR:      r = 32'(va != 0 || vb != 0);
			pie_pkg::OP_DIFFER:  r = 32'(va != vb);
			pie_pkg::OP_EQUAL:   r = 32'(va == vb);
			pie_pkg::OP_GREATER: r = 32'($signed(vb) < $signed(va));
			pie_pkg::OP_LOWER:   r = 32'($signed(va) < $signed(vb));
			default: begin
				k = pie_pkg::KIND_INT;
				case (op)
					pie_pkg::OP_DIV, pie_pkg::OP_MOD: begin
						if (vb == 0) return pie_pkg::ST_DIVZ;
						ma = va[31] ? -va : va;
						mb = vb[31] ? -vb : vb;
						q = ma / mb;
						m = ma % mb;
						if (op == pie_pkg::OP_DIV) r = (va[31] ^ vb[31]) ? -q : q;
						else r = va[31] ? -m : m;
					end
					pie_pkg::OP_MINUS: r = va - vb;
					pie_pkg::OP_MUL:   r = va * vb;
					pie_pkg::OP_PLUS:  r = va + vb;
					default:           r = '0;
				endcase
			end
		endcase
		res = '0;
		res.kind = k;
		res.val = r;
		eval_stack[eval_depth] = res;
		eval_depth++;
		return pie_pkg::ST_OK;
	endfunction

	function automatic void predict_item(pie_pkg::item_t it);
		pie_pkg::operand_t o;
		outcome_t oc;
		if (it.cls == pie_pkg::CMD_VIEW) begin
			view_val[it.slot] = it.value;
			view_ok[it.slot] = it.fresh;
			return;
		end
		if (it.cls == pie_pkg::CMD_MAP) begin
			map_tab[it.slot] = '{conn: it.conn, hash: it.hash, quant: it.quant,
				target: it.target};
			return;
		end
		if (it.cls != pie_pkg::CMD_NODE) return;
		if (eval_err == pie_pkg::ST_OK) begin
			if (it.kind == pie_pkg::KIND_CONST || it.kind == pie_pkg::KIND_ATTR) begin
				if (eval_depth >= DEPTH) eval_err = pie_pkg::ST_OVER;
				else begin
					o.kind = it.kind;
					o.val = it.value;
					o.neg = it.negated;
					o.hash = it.hash;
					o.quant = it.quant;
					eval_stack[eval_depth] = o;
					eval_depth++;
				end
			end else if (it.kind == pie_pkg::KIND_OPER) begin
				eval_err = eval_operator(it.op);
			end
		end
		if (!it.last) return;
		oc.val = '0;
		oc.is_bool = 1'b0;
		oc.st = eval_err;
		if (eval_err == pie_pkg::ST_OK && eval_depth > 0 &&
				eval_stack[eval_depth - 1].kind != pie_pkg::KIND_ATTR) begin
			oc.val = eval_stack[eval_depth - 1].val;
			oc.is_bool = (eval_stack[eval_depth - 1].kind == pie_pkg::KIND_BOOL);
		end
		expected_results.push_back(oc);
		eval_depth = 0;
		conn_count = '0;
		eval_err = pie_pkg::ST_OK;
	endfunction

	// in_valid stays high after an accept; a gap, a drain or a config write drops it
	task automatic send_item(pie_pkg::item_t it);
		int gap;
		gap = gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		command <= it.cls;
		node_kind <= it.kind;
		value <= it.value;
		negated <= it.negated;
		attr_hash <= it.hash;
		quantifier <= it.quant;
		op_code <= it.op;
		last_node <= it.last;
		slot <= it.slot;
		connective_number <= it.conn;
		target_index <= it.target;
		fresh <= it.fresh;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_item(it);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_map_count(logic [4:0] n);
		in_valid <= 1'b0;
		cfg_data <= n;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		map_limit = n;
	endtask

	function automatic pie_pkg::item_t blank_item();
		pie_pkg::item_t it;
		it = '0;
		it.cls = pie_pkg::CMD_NODE;
		return it;
	endfunction

	task automatic push_const(logic [31:0] v, bit neg, bit last);
		pie_pkg::item_t it;
		it = blank_item();
		it.kind = pie_pkg::KIND_CONST;
		it.value = v;
		it.negated = neg;
		it.last = last;
		send_item(it);
	endtask

	task automatic push_attr(logic [15:0] h, logic [7:0] q, bit neg, bit last);
		pie_pkg::item_t it;
		it = blank_item();
		it.kind = pie_pkg::KIND_ATTR;
		it.hash = h;
		it.quant = q;
		it.negated = neg;
		it.value = $urandom;
		it.last = last;
		send_item(it);
	endtask

	task automatic apply_op(logic [3:0] op, bit last);
		pie_pkg::item_t it;
		it = blank_item();
		it.kind = pie_pkg::KIND_OPER;
		it.op = op;
		it.last = last;
		send_item(it);
	endtask

	task automatic write_view(logic [3:0] s, logic [31:0] v, bit f);
		pie_pkg::item_t it;
		it = '0;
		it.cls = pie_pkg::CMD_VIEW;
		it.slot = s;
		it.value = v;
		it.fresh = f;
		send_item(it);
	endtask

	task automatic write_map(logic [3:0] s, logic [7:0] c, logic [15:0] h, logic [7:0] q,
			logic [7:0] t);
		pie_pkg::item_t it;
		it = '0;
		it.cls = pie_pkg::CMD_MAP;
		it.slot = s;
		it.conn = c;
		it.hash = h;
		it.quant = q;
		it.target = t;
		send_item(it);
	endtask

	// every mapping slot is written before any lookup can read it
	task automatic test_tables_init();
		for (int i = 0; i < MAPS; i++)
			write_map(4'(i), 8'(i % 4), 16'h0100 + 16'(i), 8'(i), (i == 15) ? 8'hFF : 8'(i));
		for (int i = 0; i < VIEWS; i++)
			write_view(4'(i), $urandom, i != 3);
		drain_results();
		write_map_count(5'd16);
	endtask

	task automatic test_operators();
		logic [31:0] ext[6] = '{32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'd0, 32'd1,
			32'h12345678};
		for (int op = 0; op < 16; op++) begin
			push_const(ext[op % 6], op[0], 1'b0);
			push_const(ext[(op + 2) % 6], op[1], 1'b0);
			apply_op(4'(op), 1'b1);
		end
		// most negative over minus one, both div and mod
		push_const(32'h80000000, 1'b0, 1'b0); push_const(32'hFFFFFFFF, 1'b0, 1'b0);
		apply_op(pie_pkg::OP_DIV, 1'b1);
		push_const(32'h80000000, 1'b0, 1'b0); push_const(32'hFFFFFFFF, 1'b0, 1'b0);
		apply_op(pie_pkg::OP_MOD, 1'b1);
		push_const(-32'sd7, 1'b0, 1'b0); push_const(32'd2, 1'b0, 1'b0);
		apply_op(pie_pkg::OP_MOD, 1'b1);
		push_const(32'd5, 1'b0, 1'b0); push_const(32'd0, 1'b0, 1'b0);
		apply_op(pie_pkg::OP_DIV, 1'b1);
	endtask

	task automatic test_errors();
		pie_pkg::item_t it;
		apply_op(pie_pkg::OP_PLUS, 1'b1);                 // underflow
		for (int i = 0; i < DEPTH + 1; i++) push_const(32'(i), 1'b0, 1'b0);
		push_const(32'd9, 1'b0, 1'b1);                    // overflow, later nodes discarded
		push_attr(16'h0100, 8'd0, 1'b0, 1'b1);            // attribute on top
		apply_op(pie_pkg::OP_AND, 1'b1);                  // empty stack then underflow
		it = blank_item(); it.kind = KIND_UNKNOWN; it.last = 1'b1;
		send_item(it);                                    // empty stack, unknown kind
		// attribute of mapping slot 3 (stale view), missed on the connective number
		push_attr(16'h0103, 8'd3, 1'b0, 1'b0); push_const(32'd1, 1'b0, 1'b0);
		apply_op(pie_pkg::OP_EQUAL, 1'b1);
		// attribute of mapping slot 15 (bad target), missed on the connective number
		push_attr(16'h010F, 8'd15, 1'b0, 1'b0); push_const(32'd1, 1'b0, 1'b0);
		apply_op(pie_pkg::OP_PLUS, 1'b1);
		// no match
		push_attr(16'hDEAD, 8'd0, 1'b0, 1'b0); push_const(32'd1, 1'b0, 1'b0);
		apply_op(pie_pkg::OP_PLUS, 1'b1);
		push_attr(16'h0100, 8'd0, 1'b1, 1'b0); push_attr(16'h0100, 8'd0, 1'b1, 1'b0);
		apply_op(pie_pkg::OP_PLUS, 1'b1);
		it = '0; it.cls = CMD_UNKNOWN; send_item(it);    // unknown command
	endtask

	task automatic random_item(output pie_pkg::item_t it);
		it.cls = ($urandom_range(0, 99) < 8) ? 2'($urandom_range(1, 3)) : pie_pkg::CMD_NODE;
		it.kind = ($urandom_range(0, 99) < 3) ? KIND_UNKNOWN : 2'($urandom_range(0, 2));
		it.value = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20) - 32'd10;
		it.negated = 1'($urandom);
		it.hash = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
			16'h0100 + 16'($urandom_range(0, 15));
		it.quant = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
		it.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15)) :
			4'($urandom_range(0, 11));
		it.last = 1'b0;
		it.slot = 4'($urandom);
		it.conn = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		it.target = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
		it.fresh = ($urandom_range(0, 5) != 0);
	endtask

	// mostly well-formed expressions: pushes balanced with operators
	task automatic test_random(int count);
		pie_pkg::item_t it;
		int sent;
		int held;
		sent = 0;
		while (sent < count) begin
			held = 0;
			for (int n = $urandom_range(1, 12); n > 0; n--) begin
				random_item(it);
				if (it.cls == pie_pkg::CMD_NODE && it.kind != KIND_UNKNOWN &&
						$urandom_range(0, 9) != 0)
					it.kind = (held >= 2 && $urandom_range(0, 1) != 0) ? pie_pkg::KIND_OPER :
						(($urandom_range(0, 2) == 0) ? pie_pkg::KIND_ATTR :
						pie_pkg::KIND_CONST);
				if (it.cls == pie_pkg::CMD_NODE && it.kind == pie_pkg::KIND_OPER) held--;
				else if (it.cls == pie_pkg::CMD_NODE && it.kind != KIND_UNKNOWN) held++;
				if (n == 1) begin
					it.cls = pie_pkg::CMD_NODE;
					it.last = 1'b1;
				end
				send_item(it);
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result value=%h bool=%b status=%0d", $time,
						result_value, result_is_bool, status);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (result_value !== e.val) begin
						$display("%0t: result_value exp %h got %h", $time, e.val, result_value);
						errors++;
					end
					if (result_is_bool !== e.is_bool) begin
						$display("%0t: result_is_bool exp %b got %b", $time, e.is_bool,
							result_is_bool);
						errors++;
					end
					if (status !== e.st) begin
						$display("%0t: status exp %0d got %0d", $time, e.st, status);
						errors++;
					end
				end
			end
			if (quiet_stall) out_stall <= 1'b0;
			else if (stall_busy) out_stall <= $urandom_range(0, 9) < 7;
			else out_stall <= $urandom_range(0, 9) < 2;
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		eval_depth = 0;
		conn_count = '0;
		eval_err = pie_pkg::ST_OK;
		map_limit = '0;
		foreach (view_ok[i]) view_ok[i] = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_map_count(5'd0);
		push_attr(16'h0100, 8'd0, 1'b0, 1'b0); push_const(32'd1, 1'b0, 1'b0);
		apply_op(pie_pkg::OP_PLUS, 1'b1);
		test_tables_init();
		test_operators();
		test_errors();
		drain_results();
		write_map_count(5'd31);
		quiet_stall = 1'b1;
		test_random(250);
		drain_results();
		write_map_count(5'd3);
		quiet_stall = 1'b0;
		stall_busy = 1'b1;
		test_random(250);
		drain_results();
		write_map_count(5'd16);
		stall_busy = 1'b0;
		test_random(300);
		drain_results();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
